[sv/htwd_pkg.sv]
// ----------------------------------------------------------------------------
// htwd_pkg
// Shared types and constants of the tree-walk decoder: field widths, request
// and result layouts, node table entry layout, operation and register codes.
// ----------------------------------------------------------------------------
package htwd_pkg;

    // table and stream sizes
    localparam int NODE_COUNT  = 1024;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int SYM_BITS    = 16;
    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int STEP_W      = $clog2(WORD_BITS + 1);
    localparam int COUNT_BITS  = 32;
    localparam int WORD_BYTES  = WORD_BITS / 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // operation codes
    localparam logic OP_LOAD_NODE = 1'b0;
    localparam logic OP_PUSH_WORD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_SYMBOL = 1'b1;

    // reset value of the null marker
    localparam logic [SYM_BITS-1:0] NULL_SYM_RESET = '1;

    // input request
    typedef struct packed {
        logic                 operation;
        logic [NODE_BITS-1:0] node_index;
        logic [NODE_BITS-1:0] left_child;
        logic [NODE_BITS-1:0] right_child;
        logic [SYM_BITS-1:0]  node_symbol;
        logic [WORD_BITS-1:0] data_word;
    } t_req_item;

    // decoded result
    typedef struct packed {
        logic [SYM_BITS-1:0]   symbol;
        logic                  last;
        logic [COUNT_BITS-1:0] byte_count;
    } t_rsp_item;

    // node table entry
    typedef struct packed {
        logic [NODE_BITS-1:0] left;
        logic [NODE_BITS-1:0] right;
        logic [SYM_BITS-1:0]  symbol;
    } t_node;

    // control states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ROOT,
        ST_RD_START,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

[sv/htwd_req_if.sv]
// ----------------------------------------------------------------------------
// htwd_req_if
// Request channel of the tree-walk decoder: valid, ready and one request.
// ----------------------------------------------------------------------------
interface htwd_req_if;
    import htwd_pkg::*;

    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/htwd_rsp_if.sv]
// ----------------------------------------------------------------------------
// htwd_rsp_if
// Result channel of the tree-walk decoder: valid, ready and one result.
// ----------------------------------------------------------------------------
interface htwd_rsp_if;
    import htwd_pkg::*;

    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/huffman_tree_walk_decoder_unit.sv]
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_unit
// Huffman decoder walking a node table in one synchronous RAM, one stream bit
// per cycle but for result stalls, lsb first; partial walks carry across words.
// ----------------------------------------------------------------------------
// Load request: written to the node table as it is accepted.
// Push request: between its acceptance and the next request come accept, root
//   read, start node read, one table read per stream bit, final leaf check and
//   flush of the last result; it stalls only while the result register is full.
// Reset: control state and control registers (byte count among them) reset; the
//   node table keeps no reset value and must be written before it is walked.
module huffman_tree_walk_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [htwd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [htwd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    htwd_req_if.sink                            i_req,
    htwd_rsp_if.source                          o_rsp
);
    import htwd_pkg::*;

    // control state
    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_W-1:0]      r_step;
    logic [NODE_BITS-1:0]   r_root_idx;
    logic [SYM_BITS-1:0]    r_null_sym;
    logic [NODE_BITS-1:0]   r_cur_node;
    logic                   r_in_prog;
    logic [COUNT_BITS-1:0]  r_bytes;
    logic                   r_pend_vld;
    logic                   r_out_vld;

    // payload
    logic [WORD_BITS-1:0]   r_word;
    logic [NODE_BITS-1:0]   r_addr;
    logic [NODE_BITS-1:0]   r_root_left;
    logic [NODE_BITS-1:0]   r_root_right;
    logic [SYM_BITS-1:0]    r_pend_sym;
    t_rsp_item              r_out;

    // table port
    logic                   ram_we;
    t_node                  ram_wdata;
    logic                   ram_re;
    logic [NODE_BITS-1:0]   ram_raddr;
    t_node                  ram_rdata;

    // walk datapath
    logic                   req_acc;
    logic                   out_free;
    logic                   hit;
    logic                   stall;
    logic                   walk_step;
    logic                   cur_bit;
    logic [NODE_BITS-1:0]   src_left;
    logic [NODE_BITS-1:0]   src_right;
    logic                   move_en;
    logic                   move_last;

    htwd_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.data.node_index),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request handshake and node loads
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign ram_we      = req_acc && (i_req.data.operation == OP_LOAD_NODE);
    assign ram_wdata   = '{left:   i_req.data.left_child,
                           right:  i_req.data.right_child,
                           symbol: i_req.data.node_symbol};

    // leaf check and child selection
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign hit       = (r_step != '0) && (ram_rdata.symbol != r_null_sym);
    assign stall     = hit && r_pend_vld && !out_free;
    assign walk_step = (r_state == ST_WALK) && !stall;
    assign cur_bit   = r_word[r_step[BIT_IDX_W-1:0]];
    assign src_left  = hit ? r_root_left  : ram_rdata.left;
    assign src_right = hit ? r_root_right : ram_rdata.right;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && (i_req.data.operation == OP_PUSH_WORD)) begin
                    n_state = ST_RD_ROOT;
                end
            end
            ST_RD_ROOT: begin
                n_state = ST_RD_START;
            end
            ST_RD_START: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_step && (r_step == STEP_W'(WORD_BITS))) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // table reads and result moves
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_root_idx;
        move_en   = 1'b0;
        move_last = 1'b0;
        case (r_state)
            ST_RD_ROOT: begin
                ram_re    = 1'b1;
                ram_raddr = r_root_idx;
            end
            ST_RD_START: begin
                ram_re    = 1'b1;
                ram_raddr = r_in_prog ? r_cur_node : r_root_idx;
            end
            ST_WALK: begin
                ram_re    = walk_step && (r_step != STEP_W'(WORD_BITS));
                ram_raddr = cur_bit ? src_right : src_left;
                move_en   = walk_step && hit && r_pend_vld;
            end
            ST_FLUSH: begin
                move_en   = r_pend_vld && out_free;
                move_last = 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_root_idx <= '0;
            r_null_sym <= NULL_SYM_RESET;
            r_cur_node <= '0;
            r_in_prog  <= 1'b0;
            r_bytes    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROOT_INDEX:  r_root_idx <= i_cfg_data[NODE_BITS-1:0];
                    CFG_NULL_SYMBOL: r_null_sym <= i_cfg_data[SYM_BITS-1:0];
                    default:         r_root_idx <= r_root_idx;
                endcase
            end

            // word start
            if (req_acc && (i_req.data.operation == OP_PUSH_WORD)) begin
                r_bytes <= r_bytes + COUNT_BITS'(WORD_BYTES);
                r_step  <= '0;
            end

            // walk progress
            if (walk_step) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step != '0) begin
                    r_in_prog  <= !hit;
                    r_cur_node <= hit ? '0 : r_addr;
                end
                if (hit) begin
                    r_pend_vld <= 1'b1;
                end
            end else if ((r_state == ST_FLUSH) && move_en) begin
                r_pend_vld <= 1'b0;
            end

            // result register
            if (move_en) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc && (i_req.data.operation == OP_PUSH_WORD)) begin
            r_word <= i_req.data.data_word;
        end
        if (ram_re) begin
            r_addr <= ram_raddr;
        end
        if (r_state == ST_RD_START) begin
            r_root_left  <= ram_rdata.left;
            r_root_right <= ram_rdata.right;
        end
        if (walk_step && hit) begin
            r_pend_sym <= ram_rdata.symbol;
        end
        if (move_en) begin
            r_out.symbol     <= r_pend_sym;
            r_out.last       <= move_last;
            r_out.byte_count <= r_bytes;
        end
    end

    // result port
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

[sv/htwd_ram.sv]
// ----------------------------------------------------------------------------
// htwd_ram
// Generic single-write, single-read synchronous RAM with registered read data
// and a read enable that holds the last read word.
// ----------------------------------------------------------------------------
module htwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/htwd_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htwd_decode_checker
// Watches the configuration port and both channels of the tree-walk decoder,
// keeps its own copy of the node table and walk state, works out the decoded
// symbols of every stream word and compares each returned result with them.
// ----------------------------------------------------------------------------
module htwd_decode_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [htwd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [htwd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    htwd_req_if                         i_req,
    htwd_rsp_if                         i_rsp,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);
    import htwd_pkg::*;

    localparam int MAX_SHOWN = 30;

    // shadow of the node table and the walk registers
    t_node                 node_mem [NODE_COUNT];
    logic [NODE_BITS-1:0]  root_sel;
    logic [SYM_BITS-1:0]   null_mark;
    logic [NODE_BITS-1:0]  walk_at;
    bit                    walking;
    logic [COUNT_BITS-1:0] bytes_taken;

    // symbols decoded so far and not yet returned
    t_rsp_item             decoded_q [$];
    t_rsp_item             oldest;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MAX_SHOWN)
            $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // walk one stream word, lsb first, queueing every leaf reached
    task automatic take_word(input logic [WORD_BITS-1:0] word);
        logic [NODE_BITS-1:0] at;
        t_rsp_item            sym_out;
        int                   last_pos;
        last_pos    = -1;
        bytes_taken = bytes_taken + COUNT_BITS'(WORD_BYTES);
        for (int b = 0; b < WORD_BITS; b++) begin
            at = walking ? walk_at : root_sel;
            at = word[b] ? node_mem[at].right : node_mem[at].left;
            if (node_mem[at].symbol != null_mark) begin
                sym_out.symbol     = node_mem[at].symbol;
                sym_out.last       = 1'b0;
                sym_out.byte_count = bytes_taken;
                decoded_q.push_back(sym_out);
                last_pos = decoded_q.size() - 1;
                walking  = 1'b0;
                walk_at  = '0;
            end else begin
                walking = 1'b1;
                walk_at = at;
            end
        end
        // flag the final symbol of this word
        if (last_pos >= 0) begin
            sym_out          = decoded_q[last_pos];
            sym_out.last     = 1'b1;
            decoded_q[last_pos] = sym_out;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_sel       = '0;
            null_mark      = NULL_SYM_RESET;
            walk_at        = '0;
            walking        = 1'b0;
            bytes_taken    = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            decoded_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROOT_INDEX:  root_sel  = i_cfg_data[NODE_BITS-1:0];
                    CFG_NULL_SYMBOL: null_mark = i_cfg_data[SYM_BITS-1:0];
                    default: ;
                endcase
            end

            // returned result against the oldest decoded symbol
            if (i_rsp.valid && i_rsp.ready) begin
                o_result_count++;
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing pending, symbol",
                                    32'(i_rsp.data.symbol), '0);
                end else begin
                    oldest = decoded_q.pop_front();
                    if (i_rsp.data.symbol !== oldest.symbol)
                        report_mismatch("symbol", 32'(i_rsp.data.symbol),
                                        32'(oldest.symbol));
                    if (i_rsp.data.last !== oldest.last)
                        report_mismatch("last flag", 32'(i_rsp.data.last),
                                        32'(oldest.last));
                    if (i_rsp.data.byte_count !== oldest.byte_count)
                        report_mismatch("byte count", i_rsp.data.byte_count,
                                        oldest.byte_count);
                end
            end

            // accepted request
            if (i_req.valid && i_req.ready) begin
                if (i_req.data.operation == OP_LOAD_NODE) begin
                    node_mem[i_req.data.node_index].left   = i_req.data.left_child;
                    node_mem[i_req.data.node_index].right  = i_req.data.right_child;
                    node_mem[i_req.data.node_index].symbol = i_req.data.node_symbol;
                end else begin
                    take_word(i_req.data.data_word);
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

[tb/tb_huffman_tree_walk_decoder_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder_unit
// Loads random Huffman trees into the decoder, sets root and null marker
// between phases, streams words through them with random gaps and result
// stalls, and leaves all checking to the decode checker beside the block.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder_unit;
    import htwd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RAND_ITEMS    = 95;
    localparam int MAX_LEAVES    = 24;
    localparam int MAX_TREE      = 2 * MAX_LEAVES;
    localparam int MAX_GAP       = 13;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    htwd_req_if req_ch ();
    htwd_rsp_if rsp_ch ();

    int chk_fails;
    int chk_pending;
    int chk_results;
    int cycle_count = 0;

    // stimulus bookkeeping
    int  n_loads = 0;
    int  n_words = 0;
    int  n_cfg   = 0;
    bit  req_steady = 1'b0;
    bit  rsp_steady = 1'b0;
    logic [SYM_BITS-1:0]  null_now;
    logic [NODE_BITS-1:0] root_now;

    // nodes written so far, so that every child points at a written node
    bit                   written [NODE_COUNT];
    logic [NODE_BITS-1:0] written_list [$];

    // tree being built: slot 0 is the root, child slot -1 marks a leaf
    logic [NODE_BITS-1:0] tree_at    [MAX_TREE];
    int                   tree_left  [MAX_TREE];
    int                   tree_right [MAX_TREE];
    int                   tree_size = 0;
    logic [SYM_BITS-1:0]  leaf_syms [$];

    huffman_tree_walk_decoder_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    htwd_decode_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending),
        .o_result_count (chk_results)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, chk_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [NODE_BITS-1:0] pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic logic [SYM_BITS-1:0] leaf_symbol(input logic [SYM_BITS-1:0] marker);
        logic [SYM_BITS-1:0] sym;
        case ($urandom_range(0, 7))
            0:       sym = '0;
            1:       sym = '1;
            default: sym = SYM_BITS'($urandom);
        endcase
        if (sym == marker)
            sym[0] = ~sym[0];
        return sym;
    endfunction

    function automatic logic [WORD_BITS-1:0] stream_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // result side: a random stall before each result
    initial begin : result_sink
        int gap;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = draw_gap(rsp_steady);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // one request, after a random gap; returns at the accepting edge
    task automatic send_request(input t_req_item item);
        int gap;
        gap = draw_gap(req_steady);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic load_node(input logic [NODE_BITS-1:0] at, input logic [NODE_BITS-1:0] lft,
                             input logic [NODE_BITS-1:0] rgt, input logic [SYM_BITS-1:0] sym);
        t_req_item item;
        item.operation   = OP_LOAD_NODE;
        item.node_index  = at;
        item.left_child  = lft;
        item.right_child = rgt;
        item.node_symbol = sym;
        item.data_word   = $urandom;
        if (!written[at]) begin
            written[at] = 1'b1;
            written_list.push_back(at);
        end
        n_loads++;
        send_request(item);
    endtask

    task automatic push_word(input logic [WORD_BITS-1:0] word);
        t_req_item item;
        item.operation   = OP_PUSH_WORD;
        item.node_index  = NODE_BITS'($urandom);
        item.left_child  = NODE_BITS'($urandom);
        item.right_child = NODE_BITS'($urandom);
        item.node_symbol = SYM_BITS'($urandom);
        item.data_word   = word;
        n_words++;
        send_request(item);
    endtask

    // stray node write, children always among written nodes
    task automatic noise_load();
        load_node(NODE_BITS'($urandom_range(0, NODE_COUNT - 1)), pick_written(),
                  pick_written(), $urandom_range(0, 1) ? null_now : 16'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        n_cfg++;
    endtask

    // wait until every decoded symbol is back and the block has gone quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random full binary tree at root, then load all of its nodes
    task automatic grow_tree(input logic [NODE_BITS-1:0] root, input int leaves,
                             input logic [SYM_BITS-1:0] marker);
        bit                   taken [NODE_COUNT];
        int                   open_slots [$];
        int                   pick;
        int                   slot;
        logic [NODE_BITS-1:0] fresh;
        logic [SYM_BITS-1:0]  sym;
        tree_size     = 1;
        tree_at[0]    = root;
        tree_left[0]  = -1;
        tree_right[0] = -1;
        taken[root]   = 1'b1;
        open_slots.push_back(0);
        leaf_syms.delete();
        // split random leaves until the tree has enough of them
        repeat (leaves - 1) begin
            pick = $urandom_range(0, open_slots.size() - 1);
            slot = open_slots[pick];
            open_slots.delete(pick);
            for (int side = 0; side < 2; side++) begin
                do fresh = NODE_BITS'($urandom_range(0, NODE_COUNT - 1)); while (taken[fresh]);
                taken[fresh]          = 1'b1;
                tree_at[tree_size]    = fresh;
                tree_left[tree_size]  = -1;
                tree_right[tree_size] = -1;
                if (side == 0)
                    tree_left[slot] = tree_size;
                else
                    tree_right[slot] = tree_size;
                open_slots.push_back(tree_size);
                tree_size++;
            end
        end
        // inner nodes carry the marker, leaves point back into the tree
        for (int s = tree_size - 1; s >= 0; s--) begin
            if (tree_left[s] >= 0) begin
                load_node(tree_at[s], tree_at[tree_left[s]], tree_at[tree_right[s]], marker);
            end else begin
                sym = leaf_symbol(marker);
                leaf_syms.push_back(sym);
                load_node(tree_at[s], tree_at[$urandom_range(0, tree_size - 1)],
                          tree_at[$urandom_range(0, tree_size - 1)], sym);
            end
        end
    endtask

    initial begin : stimulus
        int directed_items;
        int leaves;
        int words;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_ROOT_INDEX;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n        <= 1'b1;

        // two-leaf tree at root 0: every bit ends a symbol, extreme symbols
        root_now = '0;
        null_now = NULL_SYM_RESET;
        write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(root_now));
        write_reg(CFG_NULL_SYMBOL, null_now);
        load_node(10'd0, 10'd1023, 10'd1, NULL_SYM_RESET);
        load_node(10'd1023, 10'd0, 10'd0, 16'h0000);
        load_node(10'd1, 10'd0, 10'd0, 16'hfffe);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        push_word(32'ha5a5_5a5a);

        // null marker 0 and root 1023: the old inner node becomes a leaf
        settle();
        root_now = 10'd1023;
        null_now = 16'h0000;
        write_reg(CFG_NULL_SYMBOL, null_now);
        write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(root_now));
        push_word(32'h1234_5678);

        // looping inner node: a word with no symbol, walk carried into the next
        // word, and a root that holds a symbol yet is never taken as a leaf
        settle();
        root_now = 10'd5;
        null_now = 16'h8000;
        write_reg(CFG_NULL_SYMBOL, null_now);
        write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(root_now));
        load_node(10'd5, 10'd6, 10'd7, 16'h0007);
        load_node(10'd6, 10'd6, 10'd7, 16'h8000);
        load_node(10'd7, 10'd5, 10'd5, 16'h7fff);
        push_word(32'h0000_0000);
        push_word(32'h0000_0002);
        push_word(32'hffff_ffff);
        directed_items = n_loads + n_words;

        // random phases: new trees, or new root and marker over the same table
        while (n_loads + n_words - directed_items < RAND_ITEMS) begin
            settle();
            req_steady = ($urandom_range(0, 4) == 0);
            rsp_steady = ($urandom_range(0, 4) == 0);
            if (tree_size < 2 || $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0:       null_now = '0;
                    1:       null_now = '1;
                    2:       null_now = null_now;
                    default: null_now = SYM_BITS'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       root_now = '0;
                    1:       root_now = '1;
                    default: root_now = NODE_BITS'($urandom);
                endcase
                write_reg(CFG_NULL_SYMBOL, null_now);
                write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(root_now));
                leaves = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_LEAVES)
                                                     : $urandom_range(2, 6);
                grow_tree(root_now, leaves, null_now);
            end else begin
                // reinterpret the table: a leaf may turn inner, a root may move
                case ($urandom_range(0, 9))
                    0, 1, 2: null_now = SYM_BITS'($urandom);
                    3:       null_now = '0;
                    4:       null_now = '1;
                    default: null_now = leaf_syms[$urandom_range(0, leaf_syms.size() - 1)];
                endcase
                if ($urandom_range(0, 1))
                    root_now = pick_written();
                write_reg(CFG_NULL_SYMBOL, null_now);
                write_reg(CFG_ROOT_INDEX, CFG_DATA_W'(root_now));
            end
            words = $urandom_range(2, 8);
            repeat (words) begin
                if ($urandom_range(0, 11) == 0)
                    noise_load();
                push_word(stream_word());
            end
        end

        // drain and verdict
        settle();
        $display("covered %0d requests: %0d node loads, %0d stream words, %0d symbols back",
                 n_loads + n_words, n_loads, n_words, chk_results);
        $display("%0d register writes over several trees, %0d mismatches", n_cfg, chk_fails);
        if (chk_fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
